>>> design/tes_pkg.sv
// Shared types and constants of the timed event scheduler.
package tes_pkg;

    // Field widths
    localparam int CMD_W      = 2;
    localparam int TIME_W     = 48;
    localparam int NOW_W      = 48;
    localparam int NOZ_W      = 8;
    localparam int LEAD_W     = 16;

    // Threshold width: (now + lead) times 1000, below 1024 times the sum
    localparam int SUM_W      = NOW_W + 1;
    localparam int THR_W      = SUM_W + 10;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_NOZZLE_ID = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FIRE_LEAD = 1'b1;

    // Register reset values
    localparam logic [NOZ_W-1:0]  NOZZLE_RESET = '0;
    localparam logic [LEAD_W-1:0] LEAD_RESET   = 16'd10;

    // Default table size
    localparam int DEF_TABLE_DEPTH = 16;

    // Item commands
    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_TICK   = 2'd2
    } t_cmd;

    // Controller to datapath commands
    typedef struct packed {
        logic load;      // latch a new item, clear scan results
        logic clr_wr;    // clear one table entry at the address
        logic rd_en;     // read one table entry at the address
        logic commit;    // apply the item to the table, form the result
        logic out_load;  // move the result into the output register
    } t_dp_cmd;

endpackage

>>> design/tes_ctrl.sv
// Controller of the timed event scheduler: clear pass, table walk, commit, hand-off.
module tes_ctrl #(
    parameter int TABLE_DEPTH = tes_pkg::DEF_TABLE_DEPTH
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    input  logic                             i_out_stall,
    output logic                             o_in_stall,
    output logic                             o_out_valid,
    output tes_pkg::t_dp_cmd                 o_cmd_bus,
    output logic [$clog2(TABLE_DEPTH)-1:0]   o_addr
);
    import tes_pkg::*;

    localparam int ADDR_W = $clog2(TABLE_DEPTH);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_COMMIT,
        ST_FINISH
    } t_state;

    t_state              r_state, n_state;
    logic [ADDR_W-1:0]   r_addr, n_addr;
    logic                r_out_valid, n_out_valid;
    t_dp_cmd             w_cmd;
    logic                w_last;
    logic                w_out_free;

    assign w_last     = (r_addr == ADDR_W'(TABLE_DEPTH - 1));
    assign w_out_free = !r_out_valid || !i_out_stall;

    // Sequence the clear pass and the per-item walk
    always_comb begin
        n_state     = r_state;
        n_addr      = r_addr;
        n_out_valid = r_out_valid && i_out_stall;
        w_cmd       = '0;
        case (r_state)
            ST_CLEAR: begin
                w_cmd.clr_wr = 1'b1;
                if (w_last) begin
                    n_addr  = '0;
                    n_state = ST_IDLE;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    w_cmd.load = 1'b1;
                    n_addr     = '0;
                    n_state    = ST_SCAN;
                end
            end
            ST_SCAN: begin
                w_cmd.rd_en = 1'b1;
                if (w_last) begin
                    n_addr  = '0;
                    n_state = ST_DRAIN;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            ST_DRAIN: begin
                n_state = ST_COMMIT;
            end
            ST_COMMIT: begin
                w_cmd.commit = 1'b1;
                n_state      = ST_FINISH;
            end
            ST_FINISH: begin
                if (w_out_free) begin
                    w_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
                n_addr  = '0;
            end
        endcase
    end

    // Hold state, walk address and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_addr      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_addr      <= n_addr;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd_bus   = w_cmd;
    assign o_addr      = r_addr;

endmodule

>>> design/tes_datapath.sv
// Datapath of the timed event scheduler: event table, scan compare, commit and result.
module tes_datapath #(
    parameter int TABLE_DEPTH = tes_pkg::DEF_TABLE_DEPTH
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  tes_pkg::t_dp_cmd                 i_cmd_bus,
    input  logic [$clog2(TABLE_DEPTH)-1:0]   i_addr,
    input  logic                             i_cfg_we,
    input  logic [tes_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [tes_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic [tes_pkg::CMD_W-1:0]        i_cmd,
    input  logic [tes_pkg::TIME_W-1:0]       i_event_time_us,
    input  logic                             i_action_on,
    input  logic [tes_pkg::NOW_W-1:0]        i_now_ms,
    output logic                             o_fired,
    output logic [tes_pkg::NOZ_W-1:0]        o_fired_nozzle,
    output logic                             o_fired_action,
    output logic                             o_status
);
    import tes_pkg::*;

    localparam int ADDR_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);

    typedef struct packed {
        logic              valid;
        logic              act;
        logic [TIME_W-1:0] key;
    } t_entry;

    // Event table
    t_entry              r_mem [TABLE_DEPTH];
    t_entry              r_rd_word;
    logic                r_rd_vld;
    logic [ADDR_W-1:0]   r_rd_idx;

    // Latched item
    logic [CMD_W-1:0]    r_op;
    logic [TIME_W-1:0]   r_key;
    logic                r_act;
    logic [SUM_W-1:0]    r_sum;
    logic [THR_W-1:0]    r_thresh;

    // Configuration
    logic [NOZ_W-1:0]    r_nozzle;
    logic [LEAD_W-1:0]   r_lead;

    // Occupancy
    logic [CNT_W-1:0]    r_count, n_count;

    // Scan results
    logic                r_match_hit;
    logic [ADDR_W-1:0]   r_match_idx;
    logic                r_free_hit;
    logic [ADDR_W-1:0]   r_free_idx;
    logic                r_best_hit;
    logic [ADDR_W-1:0]   r_best_idx;
    logic [TIME_W-1:0]   r_best_time;
    logic                r_best_act;

    // Result and output registers
    logic                r_res_fired, n_res_fired;
    logic                r_res_act, n_res_act;
    logic                r_res_status, n_res_status;
    logic                r_out_fired;
    logic [NOZ_W-1:0]    r_out_nozzle;
    logic                r_out_act;
    logic                r_out_status;

    // Table write port
    logic                w_we;
    logic [ADDR_W-1:0]   w_waddr;
    t_entry              w_wdata;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nozzle <= NOZZLE_RESET;
            r_lead   <= LEAD_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_NOZZLE_ID: r_nozzle <= i_cfg_data[NOZ_W-1:0];
                REG_FIRE_LEAD: r_lead   <= i_cfg_data[LEAD_W-1:0];
                default: ;
            endcase
        end
    end

    // Latch the item; key/1000 < now + lead holds exactly when key < (now + lead) * 1000
    always_ff @(posedge i_clk) begin
        if (i_cmd_bus.load) begin
            r_op  <= i_cmd;
            r_key <= i_event_time_us;
            r_act <= i_action_on;
            r_sum <= {1'b0, i_now_ms} + SUM_W'(r_lead);
        end
        // times 1000 as 1024 - 16 - 8
        r_thresh <= (THR_W'(r_sum) << 10) - (THR_W'(r_sum) << 4) - (THR_W'(r_sum) << 3);
    end

    // Read one entry per cycle during the walk
    always_ff @(posedge i_clk) begin
        if (i_cmd_bus.rd_en) begin
            r_rd_word <= r_mem[i_addr];
            r_rd_idx  <= i_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd_bus.rd_en;
        end
    end

    // Track first key match, first free slot and earliest valid entry
    always_ff @(posedge i_clk) begin
        if (i_cmd_bus.load) begin
            r_match_hit <= 1'b0;
            r_free_hit  <= 1'b0;
            r_best_hit  <= 1'b0;
        end else if (r_rd_vld) begin
            if (!r_match_hit && r_rd_word.valid && r_rd_word.key == r_key) begin
                r_match_hit <= 1'b1;
                r_match_idx <= r_rd_idx;
            end
            if (!r_free_hit && !r_rd_word.valid) begin
                r_free_hit <= 1'b1;
                r_free_idx <= r_rd_idx;
            end
            if (r_rd_word.valid && (!r_best_hit || r_rd_word.key < r_best_time)) begin
                r_best_hit  <= 1'b1;
                r_best_idx  <= r_rd_idx;
                r_best_time <= r_rd_word.key;
                r_best_act  <= r_rd_word.act;
            end
        end
    end

    // Decide the table update and the result
    always_comb begin
        w_we         = 1'b0;
        w_waddr      = i_addr;
        w_wdata      = '0;
        n_count      = r_count;
        n_res_fired  = r_res_fired;
        n_res_act    = r_res_act;
        n_res_status = r_res_status;
        if (i_cmd_bus.clr_wr) begin
            w_we = 1'b1;
        end else if (i_cmd_bus.commit) begin
            n_res_fired  = 1'b0;
            n_res_act    = 1'b0;
            n_res_status = 1'b0;
            case (r_op)
                CMD_INSERT: begin
                    if (r_match_hit) begin
                        // replace the action of an existing key
                        w_we    = 1'b1;
                        w_waddr = r_match_idx;
                        w_wdata = '{valid: 1'b1, act: r_act, key: r_key};
                    end else if (r_count == CNT_W'(TABLE_DEPTH) || !r_free_hit) begin
                        // drop the item, table full
                        n_res_status = 1'b1;
                    end else begin
                        w_we    = 1'b1;
                        w_waddr = r_free_idx;
                        w_wdata = '{valid: 1'b1, act: r_act, key: r_key};
                        n_count = r_count + 1'b1;
                    end
                end
                CMD_REMOVE: begin
                    if (r_match_hit) begin
                        w_we    = 1'b1;
                        w_waddr = r_match_idx;
                        w_wdata = '{valid: 1'b0, act: 1'b0, key: r_key};
                        if (r_count != '0) begin
                            n_count = r_count - 1'b1;
                        end
                    end
                end
                CMD_TICK: begin
                    if (r_best_hit && THR_W'(r_best_time) < r_thresh) begin
                        n_res_fired = 1'b1;
                        n_res_act   = r_best_act;
                        w_we        = 1'b1;
                        w_waddr     = r_best_idx;
                        w_wdata     = '{valid: 1'b0, act: r_best_act, key: r_best_time};
                        if (r_count != '0) begin
                            n_count = r_count - 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Write the table
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
    end

    // Hold occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // Hold the result until the output register is free
    always_ff @(posedge i_clk) begin
        r_res_fired  <= n_res_fired;
        r_res_act    <= n_res_act;
        r_res_status <= n_res_status;
        if (i_cmd_bus.out_load) begin
            r_out_fired  <= r_res_fired;
            r_out_nozzle <= r_res_fired ? r_nozzle : '0;
            r_out_act    <= r_res_act;
            r_out_status <= r_res_status;
        end
    end

    assign o_fired        = r_out_fired;
    assign o_fired_nozzle = r_out_nozzle;
    assign o_fired_action = r_out_act;
    assign o_status       = r_out_status;

endmodule

>>> design/timed_event_scheduler_core.sv
// Top level of the timed event scheduler: controller, datapath and checks.
// Each result reaches the output register after a walk over the event table: one read
// per cycle over every slot, a drain step, then commit and a hand-off that waits while
// the output register is held. A new item is taken only after the hand-off; an item is taken while an earlier
// result still waits in the output register. After reset a clearing pass
// empties the table while input is stalled; config writes go on.
module timed_event_scheduler_core #(
    parameter int TABLE_DEPTH = tes_pkg::DEF_TABLE_DEPTH
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [tes_pkg::CMD_W-1:0]        i_cmd,
    input  logic [tes_pkg::TIME_W-1:0]       i_event_time_us,
    input  logic                             i_action_on,
    input  logic [tes_pkg::NOW_W-1:0]        i_now_ms,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic                             o_fired,
    output logic [tes_pkg::NOZ_W-1:0]        o_fired_nozzle,
    output logic                             o_fired_action,
    output logic                             o_status,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [tes_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [tes_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import tes_pkg::*;

    localparam int ADDR_W = $clog2(TABLE_DEPTH);

    t_dp_cmd            w_cmd_bus;
    logic [ADDR_W-1:0]  w_addr;
    logic               w_cfg_we;

    // Registers are always writable
    assign o_cfg_ready = 1'b1;
    assign w_cfg_we    = i_cfg_valid && o_cfg_ready;

    tes_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_cmd_bus   (w_cmd_bus),
        .o_addr      (w_addr)
    );

    tes_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd_bus       (w_cmd_bus),
        .i_addr          (w_addr),
        .i_cfg_we        (w_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_cmd           (i_cmd),
        .i_event_time_us (i_event_time_us),
        .i_action_on     (i_action_on),
        .i_now_ms        (i_now_ms),
        .o_fired         (o_fired),
        .o_fired_nozzle  (o_fired_nozzle),
        .o_fired_action  (o_fired_action),
        .o_status        (o_status)
    );

    // Reset starts the clearing pass with input stalled
    a_reset_stall: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_stall)
        else $error("input not stalled after reset");

    // One item at a time: acceptance closes the input
    a_accept_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input open right after an accepted item");

    // Datapath commands never overlap
    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd_bus.load, w_cmd_bus.clr_wr, w_cmd_bus.rd_en,
                  w_cmd_bus.commit, w_cmd_bus.out_load}))
        else $error("overlapping datapath commands");

    // A result appears only through a result load
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_cmd_bus.out_load))
        else $error("output valid without result load");

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench of the timed event scheduler core with its own scheduler model.
module tb;
    import tes_pkg::*;

    localparam int DEPTH          = DEF_TABLE_DEPTH;
    localparam int US_PER_MS      = 1000;
    localparam int LEAD_AT_RESET  = 10;
    localparam int MAX_GAP        = 12;
    localparam int SETTLE_CYCLES  = 2 * (DEPTH + 4);
    localparam int CYCLE_LIMIT    = 1_000_000;
    localparam int MAX_REPORTS    = 10;
    localparam int PHASE_ITEMS    = 325;
    localparam logic [CMD_W-1:0]  CMD_UNUSED = 2'd3;
    localparam logic [TIME_W-1:0] TIME_MAX   = '1;
    localparam logic [NOW_W-1:0]  NOW_MAX    = '1;

    typedef struct packed {
        logic             fired;
        logic [NOZ_W-1:0] nozzle;
        logic             action;
        logic             status;
    } t_result;

    logic                  i_clk           = 1'b0;
    logic                  i_rst_n         = 1'b0;
    logic                  i_in_valid      = 1'b0;
    logic                  o_in_stall;
    logic [CMD_W-1:0]      i_cmd           = '0;
    logic [TIME_W-1:0]     i_event_time_us = '0;
    logic                  i_action_on     = 1'b0;
    logic [NOW_W-1:0]      i_now_ms        = '0;
    logic                  o_out_valid;
    logic                  i_out_stall     = 1'b0;
    logic                  o_fired;
    logic [NOZ_W-1:0]      o_fired_nozzle;
    logic                  o_fired_action;
    logic                  o_status;
    logic                  i_cfg_valid     = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index     = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data      = '0;

    // Scheduler model state
    logic [TIME_W-1:0] sched_time   [DEPTH];
    logic              sched_action [DEPTH];
    logic              sched_live   [DEPTH];
    int                sched_count;
    logic [NOZ_W-1:0]  nozzle_reg;
    logic [LEAD_W-1:0] lead_reg;
    t_result           pending_q[$];

    bit tx_idle     = 1'b1;
    bit rx_idle     = 1'b1;
    bit rx_taken    = 1'b0;
    int rx_hold     = 0;
    int mismatches  = 0;
    int cycle_count = 0;

    timed_event_scheduler_core #(
        .TABLE_DEPTH (DEPTH)
    ) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_cmd           (i_cmd),
        .i_event_time_us (i_event_time_us),
        .i_action_on     (i_action_on),
        .i_now_ms        (i_now_ms),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_fired         (o_fired),
        .o_fired_nozzle  (o_fired_nozzle),
        .o_fired_action  (o_fired_action),
        .o_status        (o_status),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    // Clock: 10 ns period
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Apply one item to the scheduler model and return the result it yields
    function automatic t_result schedule_step(input logic [CMD_W-1:0] cmd,
                                              input logic [TIME_W-1:0] key,
                                              input logic act,
                                              input logic [NOW_W-1:0] now);
        t_result     res;
        int          hit;
        int          slot;
        logic [63:0] event_ms;
        logic [63:0] limit_ms;
        res  = '0;
        hit  = -1;
        slot = -1;
        for (int i = 0; i < DEPTH; i++)
            if (sched_live[i] && sched_time[i] == key)
                hit = i;
        case (cmd)
            CMD_INSERT: begin
                if (hit >= 0) begin
                    sched_action[hit] = act;
                end else if (sched_count >= DEPTH) begin
                    res.status = 1'b1;
                end else begin
                    for (int i = DEPTH - 1; i >= 0; i--)
                        if (!sched_live[i])
                            slot = i;
                    sched_time[slot]   = key;
                    sched_action[slot] = act;
                    sched_live[slot]   = 1'b1;
                    sched_count++;
                end
            end
            CMD_REMOVE: begin
                if (hit >= 0) begin
                    sched_live[hit] = 1'b0;
                    sched_count--;
                end
            end
            CMD_TICK: begin
                for (int i = 0; i < DEPTH; i++)
                    if (sched_live[i] && (slot < 0 || sched_time[i] < sched_time[slot]))
                        slot = i;
                if (slot >= 0) begin
                    event_ms = 64'(sched_time[slot]) / US_PER_MS;
                    limit_ms = 64'(now) + 64'(lead_reg);
                    // fire when the earliest event lies less than the lead ahead
                    if (event_ms < limit_ms) begin
                        res.fired  = 1'b1;
                        res.nozzle = nozzle_reg;
                        res.action = sched_action[slot];
                        sched_live[slot] = 1'b0;
                        sched_count--;
                    end
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    // Pick the key of a random live entry; leave key alone when the table is empty
    function automatic bit pick_live_key(inout logic [TIME_W-1:0] key);
        int start;
        int idx;
        start = $urandom_range(0, DEPTH - 1);
        for (int i = 0; i < DEPTH; i++) begin
            idx = (start + i) % DEPTH;
            if (sched_live[idx]) begin
                key = sched_time[idx];
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // Send one item, after a random gap while tx_idle is set, and record its expected result
    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [TIME_W-1:0] key,
                             input logic act, input logic [NOW_W-1:0] now);
        int gap;
        gap = tx_idle ? $urandom_range(0, MAX_GAP) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid      = 1'b1;
        i_cmd           = cmd;
        i_event_time_us = key;
        i_action_on     = act;
        i_now_ms        = now;
        do @(posedge i_clk); while (o_in_stall);
        pending_q.push_back(schedule_step(cmd, key, act, now));
    endtask

    // Hold off input until every pending result has come back
    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == REG_NOZZLE_ID)
            nozzle_reg = data[NOZ_W-1:0];
        else
            lead_reg = data[LEAD_W-1:0];
    endtask

    // Write both registers while the block is idle; upper nozzle bits carry junk
    task automatic set_config(input logic [NOZ_W-1:0] nozzle, input logic [LEAD_W-1:0] lead);
        drain_results();
        write_reg(REG_NOZZLE_ID, {8'($urandom), nozzle});
        write_reg(REG_FIRE_LEAD, lead);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic report_mismatch(input string what, input t_result want, input t_result got);
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            $display("%t %s: expected fired=%0d nozzle=%0h action=%0d status=%0d",
                     $time, what, want.fired, want.nozzle, want.action, want.status);
            $display("    got fired=%0d nozzle=%0h action=%0d status=%0d",
                     got.fired, got.nozzle, got.action, got.status);
        end
    endtask

    // Compare each accepted result with the oldest pending one
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = {o_fired, o_fired_nozzle, o_fired_action, o_status};
            if (pending_q.size() == 0) begin
                report_mismatch("unexpected result", '0, got);
            end else begin
                want = pending_q.pop_front();
                if (got.fired !== want.fired || got.nozzle !== want.nozzle ||
                    got.action !== want.action || got.status !== want.status)
                    report_mismatch("result mismatch", want, got);
            end
        end
        rx_taken = i_rst_n && o_out_valid && !i_out_stall;
    end

    // Draw a wait after each taken result while rx_idle is set, and stall the result side for it
    always @(negedge i_clk) begin
        if (rx_taken)
            rx_hold = rx_idle ? $urandom_range(0, MAX_GAP) : 0;
        if (rx_hold > 0) begin
            i_out_stall = 1'b1;
            rx_hold--;
        end else begin
            i_out_stall = 1'b0;
        end
    end

    // Empty-table tick, missing-key remove, unused command
    task automatic test_empty_and_unused();
        send_item(CMD_TICK, TIME_W'({$urandom, $urandom}), 1'b1, '0);
        send_item(CMD_REMOVE, 48'd123_456, 1'b0, NOW_MAX);
        send_item(CMD_UNUSED, TIME_MAX, 1'b1, NOW_MAX);
    endtask

    // Extreme keys and times, overdue event at the largest now
    task automatic test_time_extremes();
        send_item(CMD_INSERT, '0, 1'b1, '0);
        send_item(CMD_INSERT, TIME_MAX, 1'b0, NOW_MAX);
        send_item(CMD_TICK, TIME_MAX, 1'b0, '0);
        set_config(8'hFF, '0);
        send_item(CMD_TICK, '0, 1'b1, NOW_MAX);
    endtask

    // Largest lead: one tick just short of the threshold, one just inside
    task automatic test_lead_limit();
        set_config(8'hA5, 16'hFFFF);
        send_item(CMD_INSERT, 48'd70_000_000, 1'b1, '0);
        send_item(CMD_TICK, '0, 1'b0, 48'd4_465);
        send_item(CMD_TICK, '0, 1'b0, 48'd4_466);
    endtask

    // Fill the table, drop a new key, replace and remove while full
    task automatic test_full_table();
        set_config(8'h5A, 16'(LEAD_AT_RESET));
        for (int i = 0; i < DEPTH; i++)
            send_item(CMD_INSERT, TIME_W'((i + 1) * 1_000_000 + i), 1'(i), '0);
        send_item(CMD_INSERT, 48'd999_999_999, 1'b1, '0);
        send_item(CMD_INSERT, 48'd3_000_002, 1'b0, '0);
        send_item(CMD_REMOVE, 48'd5_000_004, 1'b0, '0);
    endtask

    // Mostly well-formed traffic around a running clock, with noise keys and times
    task automatic test_random_traffic(input int n_items, input logic [NOW_W-1:0] base_ms);
        logic [NOW_W-1:0]  clock_ms;
        logic [TIME_W-1:0] key;
        logic [NOW_W-1:0]  now;
        logic [CMD_W-1:0]  cmd;
        logic              act;
        int                tick_pct;
        int                kind;
        int                pick;
        clock_ms = base_ms;
        tick_pct = 45;
        for (int n = 0; n < n_items; n++) begin
            // switch idling and command mix every stretch
            if (n % 50 == 0) begin
                tx_idle  = ($urandom_range(0, 3) != 0);
                rx_idle  = ($urandom_range(0, 3) != 0);
                tick_pct = $urandom_range(0, 1) ? 55 : 20;
            end
            key  = TIME_W'({$urandom, $urandom});
            now  = NOW_W'({$urandom, $urandom});
            act  = 1'($urandom);
            kind = $urandom_range(0, 99);
            if (kind < 2) begin
                cmd = CMD_UNUSED;
            end else if (kind < 2 + tick_pct) begin
                cmd = CMD_TICK;
                if ($urandom_range(0, 19) != 0) begin
                    now      = clock_ms;
                    clock_ms = clock_ms + NOW_W'($urandom_range(0, 25));
                end
            end else if (kind < 17 + tick_pct) begin
                cmd = CMD_REMOVE;
                if ($urandom_range(0, 3) != 0)
                    void'(pick_live_key(key));
            end else begin
                cmd  = CMD_INSERT;
                pick = $urandom_range(0, 9);
                if (pick < 2)
                    void'(pick_live_key(key));
                else if (pick < 9)
                    key = TIME_W'((64'(clock_ms) + $urandom_range(0, 80)) * US_PER_MS
                                  + $urandom_range(0, 999));
            end
            send_item(cmd, key, act, now);
        end
        tx_idle = 1'b1;
        rx_idle = 1'b1;
    endtask

    // Random traffic under several register settings, extremes among them
    task automatic test_random_phases();
        set_config(8'($urandom), 16'(LEAD_AT_RESET));
        test_random_traffic(PHASE_ITEMS, 48'd1_000);
        set_config('0, '0);
        test_random_traffic(PHASE_ITEMS, NOW_W'($urandom_range(0, 32'h3FFF_FFFF)));
        set_config(8'hFF, 16'hFFFF);
        test_random_traffic(PHASE_ITEMS, NOW_W'({$urandom_range(0, 31), $urandom}));
        set_config(8'($urandom), 16'($urandom_range(0, 40)));
        test_random_traffic(PHASE_ITEMS, 48'd281_474_970_000);
    endtask

    initial begin
        for (int i = 0; i < DEPTH; i++) begin
            sched_time[i]   = '0;
            sched_action[i] = 1'b0;
            sched_live[i]   = 1'b0;
        end
        sched_count = 0;
        nozzle_reg  = '0;
        lead_reg    = 16'(LEAD_AT_RESET);

        // hold reset, then release it on a falling edge
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_empty_and_unused();
        test_time_extremes();
        test_lead_limit();
        test_full_table();
        test_random_phases();

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
